### rtl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types and constants of the FAT16 cluster chain manager: entry codes,
// command and status codes, sequencer states and the table access struct.
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam int VAL_W     = 16;  // table entry and result value width
  localparam int PTR_W     = 16;  // cluster pointer width in the sequencer
  localparam int CLUSTER_W = 12;
  localparam int COUNT_W   = 8;
  localparam int CFG_W     = 13;
  localparam int SIZE_W    = 17;  // holds the table size up to 65536

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [VAL_W-1:0] ENTRY_FREE  = 16'h0000;
  localparam logic [VAL_W-1:0] ENTRY_END   = 16'hFFFF;
  localparam logic [VAL_W-1:0] ENTRY_MEDIA = 16'hFFF8;

  localparam logic [PTR_W-1:0] ALLOC_BASE = 16'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ALLOC_END,
    S_FREE_RD,
    S_FREE_CHK,
    S_READ_WAIT
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

### rtl/fccm_table.sv
// ----------------------------------------------------------------------------
// fccm_table
// Single-port allocation table memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module fccm_table #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF,
  parameter int AW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk_i,
  input  fccm_pkg::mem_ctl_t         mem_ctl_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [fccm_pkg::VAL_W-1:0] wdata_i,
  output logic [fccm_pkg::VAL_W-1:0] rdata_o
);
  import fccm_pkg::*;

  logic [VAL_W-1:0] mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (mem_ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fccm_ctrl.sv
// ----------------------------------------------------------------------------
// fccm_ctrl
// Command sequencer: clearing pass, first-fit chain allocation with rollback,
// chain free walk, single entry read and write. One pointer register with a
// shared incrementer and range compare drives the scan and free walk accesses.
// ----------------------------------------------------------------------------
module fccm_ctrl #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF,
  parameter int AW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd_i,
  input  logic [fccm_pkg::CLUSTER_W-1:0] cluster_i,
  input  logic [fccm_pkg::COUNT_W-1:0]   count_i,
  input  logic [fccm_pkg::VAL_W-1:0]     entry_value_i,
  input  logic [fccm_pkg::SIZE_W-1:0]    size_i,
  output logic                           done_o,
  output logic [fccm_pkg::VAL_W-1:0]     value_o,
  output logic [1:0]                     status_o,
  output fccm_pkg::mem_ctl_t             mem_ctl_o,
  output logic [AW-1:0]                  mem_addr_o,
  output logic [fccm_pkg::VAL_W-1:0]     mem_wdata_o,
  input  logic [fccm_pkg::VAL_W-1:0]     mem_rdata_i
);
  import fccm_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [PTR_W-1:0]    cur_q, cur_d;
  logic [PTR_W-1:0]    first_q, first_d;
  logic [AW-1:0]       prev_q, prev_d;
  logic [COUNT_W-1:0]  got_q, got_d;
  logic [COUNT_W-1:0]  want_q, want_d;
  logic                fail_q, fail_d;
  logic                done_q, done_d;
  logic [VAL_W-1:0]    value_q, value_d;
  logic [1:0]          status_q, status_d;

  logic [PTR_W-1:0]    cur_inc;
  logic                cur_lt_n;
  logic [COUNT_W-1:0]  got_inc;
  logic [PTR_W-1:0]    cl_ext;
  logic                cl_in_range;

  // shared pointer unit
  assign cur_inc     = cur_q + PTR_W'(1);
  assign cur_lt_n    = {1'b0, cur_q} < size_i;
  assign got_inc     = got_q + COUNT_W'(1);
  assign cl_ext      = {{(PTR_W-CLUSTER_W){1'b0}}, cluster_i};
  assign cl_in_range = {{(SIZE_W-CLUSTER_W){1'b0}}, cluster_i} < size_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      fail_q  <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    first_q  <= first_d;
    prev_q   <= prev_d;
    got_q    <= got_d;
    want_q   <= want_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    first_d     = first_q;
    prev_d      = prev_q;
    got_d       = got_q;
    want_d      = want_q;
    fail_d      = fail_q;
    done_d      = 1'b0;
    value_d     = value_q;
    status_d    = status_q;
    mem_ctl_o   = '0;
    mem_addr_o  = cur_q[AW-1:0];
    mem_wdata_o = ENTRY_FREE;

    case (state_q)
      S_CLEAR: begin
        mem_ctl_o.wr = 1'b1;
        mem_addr_o   = clr_q;
        if (clr_q == AW'(0)) begin
          mem_wdata_o = ENTRY_MEDIA;
        end else if (clr_q == AW'(1)) begin
          mem_wdata_o = ENTRY_END;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              if (count_i == '0) begin
                done_d   = 1'b1;
                value_d  = '0;
                status_d = ST_OK;
              end else begin
                want_d  = count_i;
                got_d   = '0;
                fail_d  = 1'b0;
                cur_d   = ALLOC_BASE;
                state_d = S_SCAN_RD;
              end
            end
            CMD_FREE: begin
              cur_d   = cl_ext;
              fail_d  = 1'b0;
              state_d = S_FREE_RD;
            end
            CMD_READ: begin
              if (cl_in_range) begin
                mem_ctl_o.rd = 1'b1;
                mem_addr_o   = cl_ext[AW-1:0];
                state_d      = S_READ_WAIT;
              end else begin
                done_d   = 1'b1;
                value_d  = '0;
                status_d = ST_RANGE;
              end
            end
            CMD_WRITE: begin
              done_d  = 1'b1;
              value_d = '0;
              if (cl_in_range) begin
                mem_ctl_o.wr = 1'b1;
                mem_addr_o   = cl_ext[AW-1:0];
                mem_wdata_o  = entry_value_i;
                status_d     = ST_OK;
              end else begin
                status_d = ST_RANGE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (cur_lt_n) begin
          mem_ctl_o.rd = 1'b1;
          state_d      = S_SCAN_CHK;
        end else if (got_q == '0) begin
          done_d   = 1'b1;
          value_d  = '0;
          status_d = ST_NOSPACE;
          state_d  = S_IDLE;
        end else begin
          // table ran out: terminate the partial chain, then roll it back
          fail_d  = 1'b1;
          state_d = S_ALLOC_END;
        end
      end

      S_SCAN_CHK: begin
        if (mem_rdata_i == ENTRY_FREE) begin
          if (got_q == '0) begin
            first_d = cur_q;
          end else begin
            // link the previous chain member to this one
            mem_ctl_o.wr = 1'b1;
            mem_addr_o   = prev_q;
            mem_wdata_o  = cur_q;
          end
          prev_d = cur_q[AW-1:0];
          got_d  = got_inc;
          if (got_inc == want_q) begin
            state_d = S_ALLOC_END;
          end else begin
            cur_d   = cur_inc;
            state_d = S_SCAN_RD;
          end
        end else begin
          cur_d   = cur_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_ALLOC_END: begin
        mem_ctl_o.wr = 1'b1;
        mem_addr_o   = prev_q;
        mem_wdata_o  = ENTRY_END;
        if (fail_q) begin
          cur_d   = first_q;
          state_d = S_FREE_RD;
        end else begin
          done_d   = 1'b1;
          value_d  = first_q;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end

      S_FREE_RD: begin
        if (cur_q >= ALLOC_BASE && cur_lt_n) begin
          mem_ctl_o.rd = 1'b1;
          state_d      = S_FREE_CHK;
        end else begin
          done_d   = 1'b1;
          value_d  = '0;
          status_d = fail_q ? ST_NOSPACE : ST_OK;
          state_d  = S_IDLE;
        end
      end

      S_FREE_CHK: begin
        if (mem_rdata_i == ENTRY_FREE) begin
          done_d   = 1'b1;
          value_d  = '0;
          status_d = fail_q ? ST_NOSPACE : ST_OK;
          state_d  = S_IDLE;
        end else begin
          // zero before moving on, so a cyclic chain stops at a free entry
          mem_ctl_o.wr = 1'b1;
          mem_wdata_o  = ENTRY_FREE;
          if (mem_rdata_i == ENTRY_END) begin
            done_d   = 1'b1;
            value_d  = '0;
            status_d = fail_q ? ST_NOSPACE : ST_OK;
            state_d  = S_IDLE;
          end else begin
            cur_d   = mem_rdata_i;
            state_d = S_FREE_RD;
          end
        end
      end

      S_READ_WAIT: begin
        done_d   = 1'b1;
        value_d  = mem_rdata_i;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

### rtl/fat16_cluster_chain_manager_core.sv
// ----------------------------------------------------------------------------
// fat16_cluster_chain_manager_core
// FAT16 allocation table with chain allocate, chain free, entry read and
// entry write commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken when start is high and busy is low. Its result
//   (value_o, status_o) is shown for exactly one cycle with done_o high; the
//   receiver cannot stall, so done_o is a pure strobe. busy drops in the same
//   cycle that done_o rises, so the next item may be issued right away.
//   cfg_we_i writes entries_in_use; write it only while no command is open.
// Sequencing, set by the single-port table and one pointer unit:
//   write entry: written from idle; read entry: a table read, then the report.
//   allocate: each entry from entry 2 on is read and checked, then the
//   chain is ended and reported; when the table runs out with part of a
//   chain built, that chain is ended, then rolled back by a free walk.
//   free: each chain entry is read, then zeroed; the walk also ends on a
//   pointer outside the table.
// Reset:
//   rst_ni clears the control state and sets entries_in_use to 4096. A
//   clearing pass over every table entry then loads the formatted table
//   (entry 0 media mark, entry 1 end mark, the rest free) with busy high.
// ----------------------------------------------------------------------------
module fat16_cluster_chain_manager_core #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd_i,
  input  logic [fccm_pkg::CLUSTER_W-1:0] cluster_i,
  input  logic [fccm_pkg::COUNT_W-1:0]   count_i,
  input  logic [fccm_pkg::VAL_W-1:0]     entry_value_i,
  input  logic                           cfg_we_i,
  input  logic [fccm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [fccm_pkg::VAL_W-1:0]     value_o,
  output logic [1:0]                     status_o
);
  import fccm_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(TABLE_ENTRIES);

  logic [CFG_W-1:0]  cfg_q;
  logic [SIZE_W-1:0] cfg_ext;
  logic [SIZE_W-1:0] size;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_addr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [VAL_W-1:0]  mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // effective table size, saturated to the memory depth
  assign cfg_ext = {{(SIZE_W-CFG_W){1'b0}}, cfg_q};
  assign size    = (cfg_ext > MAX_SIZE) ? MAX_SIZE : cfg_ext;

  fccm_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .cluster_i     (cluster_i),
    .count_i       (count_i),
    .entry_value_i (entry_value_i),
    .size_i        (size),
    .done_o        (done_o),
    .value_o       (value_o),
    .status_o      (status_o),
    .mem_ctl_o     (mem_ctl),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  fccm_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_table (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .addr_i    (mem_addr),
    .wdata_i   (mem_wdata),
    .rdata_o   (mem_rdata)
  );

endmodule
